// File: sv/alpha_blit_with_clipping_unit_assert.svh
// Assertion helpers for the blitter RTL.
`ifndef ALPHA_BLIT_WITH_CLIPPING_UNIT_ASSERT_SVH
`define ALPHA_BLIT_WITH_CLIPPING_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ABWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/abwc_pkg.sv
package abwc_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 11;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 9;
  localparam int COUNT_W    = 8;
  localparam int MODE_W     = 2;
  localparam int ALPHA_W    = 8;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Slave tdata layout, lowest field first.
  localparam int OX_LSB     = 0;
  localparam int OY_LSB     = OX_LSB + COORD_W;
  localparam int RW_LSB     = OY_LSB + COORD_W;
  localparam int RH_LSB     = RW_LSB + SIZE_W;
  localparam int BM_LSB     = RH_LSB + SIZE_W;
  localparam int CA_LSB     = BM_LSB + MODE_W;
  localparam int PC_LSB     = CA_LSB + ALPHA_W;
  localparam int IN_BITS    = PC_LSB + COLOR_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_COPY        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SRC_ALPHA   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONST_ALPHA = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SURF_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_H = 2'd1;

  localparam logic [SIZE_W-1:0] RECT_MAX = 9'd256;

  typedef struct packed {
    logic is_pixel;
    logic is_read;
    logic on_surf;
    logic blend;
    logic last;
  } op_ctl_t;

endpackage

// File: sv/abwc_ram.sv
module abwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/abwc_front.sv
module abwc_front #(
  parameter int MAX_W = 256,
  parameter int MAX_H = 256,
  localparam int AW = (MAX_W * MAX_H > 1) ? $clog2(MAX_W * MAX_H) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [abwc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [abwc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             fire_i,
  input  logic [abwc_pkg::CMD_W-1:0]       cmd_i,
  input  logic signed [abwc_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [abwc_pkg::COORD_W-1:0] origin_y_i,
  input  logic [abwc_pkg::SIZE_W-1:0]      rect_width_i,
  input  logic [abwc_pkg::SIZE_W-1:0]      rect_height_i,
  input  logic [abwc_pkg::MODE_W-1:0]      blend_mode_i,
  input  logic [abwc_pkg::ALPHA_W-1:0]     const_alpha_i,
  input  logic [abwc_pkg::ALPHA_W-1:0]     pixel_alpha_i,
  output abwc_pkg::op_ctl_t                ctl_o,
  output logic [AW-1:0]                    addr_o,
  output logic [abwc_pkg::ALPHA_W-1:0]     alpha_o
);
  import abwc_pkg::*;

  localparam int SW_MAX = (MAX_W < 511) ? MAX_W : 511;
  localparam int SH_MAX = (MAX_H < 511) ? MAX_H : 511;
  localparam int SW_RST = (MAX_W < 256) ? MAX_W : 256;
  localparam int SH_RST = (MAX_H < 256) ? MAX_H : 256;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]         sw_q, sh_q;
  logic signed [COORD_W-1:0] org_x_q, org_y_q;
  logic [SIZE_W-1:0]         cols_q, rows_q;
  logic [MODE_W-1:0]         mode_q;
  logic [ALPHA_W-1:0]        alpha_q;
  logic [COUNT_W-1:0]        col_q, row_q;

  logic                      is_pixel, is_read;
  logic [POS_W-1:0]          pos_x, pos_y;
  logic                      on_surf;
  logic                      col_last, row_last;
  logic [SIZE_W-1:0]         x_lo, y_lo;

  assign is_pixel = (cmd_i == CMD_PIXEL);
  assign is_read  = (cmd_i == CMD_READ);

  always_comb begin
    if (is_read) begin
      pos_x = {origin_x_i[COORD_W-1], origin_x_i};
      pos_y = {origin_y_i[COORD_W-1], origin_y_i};
    end else begin
      pos_x = {org_x_q[COORD_W-1], org_x_q} + {{(POS_W-COUNT_W){1'b0}}, col_q};
      pos_y = {org_y_q[COORD_W-1], org_y_q} + {{(POS_W-COUNT_W){1'b0}}, row_q};
    end
  end

  assign on_surf = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
                   (pos_x[POS_W-2:0] < {{(POS_W-1-SIZE_W){1'b0}}, sw_q}) &&
                   (pos_y[POS_W-2:0] < {{(POS_W-1-SIZE_W){1'b0}}, sh_q});

  // On the surface both coordinates stay below the register limits.
  assign x_lo   = pos_x[SIZE_W-1:0];
  assign y_lo   = pos_y[SIZE_W-1:0];
  assign addr_o = AW'(32'(y_lo) * MAX_W + 32'(x_lo));

  assign col_last = (SIZE_W'(col_q) + SIZE_W'(1)) >= cols_q;
  assign row_last = (SIZE_W'(row_q) + SIZE_W'(1)) >= rows_q;

  assign ctl_o.is_pixel = is_pixel;
  assign ctl_o.is_read  = is_read;
  assign ctl_o.on_surf  = on_surf;
  assign ctl_o.blend    = (mode_q == MODE_SRC_ALPHA) || (mode_q == MODE_CONST_ALPHA);
  assign ctl_o.last     = is_pixel && col_last && row_last;
  assign alpha_o        = (mode_q == MODE_SRC_ALPHA) ? pixel_alpha_i : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= SIZE_W'(SW_RST);
      sh_q    <= SIZE_W'(SH_RST);
      org_x_q <= '0;
      org_y_q <= '0;
      cols_q  <= SIZE_W'(1);
      rows_q  <= SIZE_W'(1);
      mode_q  <= MODE_COPY;
      alpha_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SURF_W) begin
          sw_q <= clamp_size(cfg_data_i, SIZE_W'(SW_MAX));
        end else if (cfg_index_i == REG_SURF_H) begin
          sh_q <= clamp_size(cfg_data_i, SIZE_W'(SH_MAX));
        end
      end
      if (fire_i) begin
        unique case (cmd_i)
          CMD_BEGIN: begin
            org_x_q <= origin_x_i;
            org_y_q <= origin_y_i;
            cols_q  <= clamp_size(rect_width_i, RECT_MAX);
            rows_q  <= clamp_size(rect_height_i, RECT_MAX);
            mode_q  <= blend_mode_i;
            alpha_q <= const_alpha_i;
            col_q   <= '0;
            row_q   <= '0;
          end
          CMD_PIXEL: begin
            // Advance in raster order, wrapping back to the top-left corner.
            if (col_last) begin
              col_q <= '0;
              row_q <= row_last ? '0 : row_q + COUNT_W'(1);
            end else begin
              col_q <= col_q + COUNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: sv/abwc_mix.sv
module abwc_mix (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [abwc_pkg::COLOR_W-1:0] src_i,
  input  logic [abwc_pkg::COLOR_W-1:0] dst_i,
  input  logic [abwc_pkg::ALPHA_W-1:0] alpha_i,
  output logic [abwc_pkg::COLOR_W-1:0] blend_o
);
  import abwc_pkg::*;

  localparam int CH_W  = 8;
  localparam int NCH   = 3;
  localparam int SUM_W = 2 * CH_W + 1;

  logic [SUM_W-1:0] sums_d [NCH];
  logic [SUM_W-1:0] sums_q [NCH];
  logic [CH_W-1:0]  dst_alpha_q;
  logic [CH_W-1:0]  chan [NCH];

  // Stage one: weighted sum per channel.
  always_comb begin
    logic [2*CH_W-1:0] p_src;
    logic [2*CH_W-1:0] p_dst;
    for (int c = 0; c < NCH; c++) begin
      p_src     = {{CH_W{1'b0}}, alpha_i} * {{CH_W{1'b0}}, src_i[CH_W*c +: CH_W]};
      p_dst     = {{CH_W{1'b0}}, ~alpha_i} * {{CH_W{1'b0}}, dst_i[CH_W*c +: CH_W]};
      sums_d[c] = {1'b0, p_src} + {1'b0, p_dst};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q      <= sums_d;
      dst_alpha_q <= dst_i[COLOR_W-1 -: CH_W];
    end
  end

  // Stage two: round to nearest and divide by 255 as (q + q/256 + 1) / 256.
  always_comb begin
    logic [SUM_W-1:0] q;
    logic [SUM_W-1:0] t;
    for (int c = 0; c < NCH; c++) begin
      q       = sums_q[c] + SUM_W'(127);
      t       = q + (q >> CH_W) + SUM_W'(1);
      chan[c] = t[2*CH_W-1:CH_W];
    end
  end

  assign blend_o = {dst_alpha_q, chan[2], chan[1], chan[0]};

endmodule

// File: sv/alpha_blit_with_clipping_unit.sv
// Blitter with an ARGB8888 frame store of MAX_SURFACE_WIDTH x MAX_SURFACE_HEIGHT words held
// in one synchronous RAM. Every beat (begin, pixel, read, unused) returns exactly one result
// beat, in order, through stage one, stage two and the output register. One command is
// taken per clock while the result side accepts and no hazard holds it: the pipe reads the
// RAM, blends (multiply, then divide by 255) and writes back, forwarding the last written
// word. A blending pixel or a read whose word is being written by the beat just ahead of it
// is held while that write is in stage one (longer if the result side stalls), so 1x1
// rectangles in a blending mode run below that rate; larger rectangles and copies run at one
// pixel per clock while the result side accepts. The store is not cleared at reset: fill it
// with a copy rectangle before blending onto it or reading it back. The user must write the
// surface size through the config port while no command is in flight; this is not enforced.
`include "alpha_blit_with_clipping_unit_assert.svh"

module alpha_blit_with_clipping_unit #(
  parameter int MAX_SURFACE_WIDTH  = 256,
  parameter int MAX_SURFACE_HEIGHT = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [abwc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [abwc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // origin_x, origin_y, rect_width, rect_height, blend_mode, const_alpha, pixel_color
  input  logic [abwc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [abwc_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_color
  output logic [abwc_pkg::COLOR_W-1:0]      m_axis_tdata,
  // pixel_written, pixel_clipped
  output logic [abwc_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast
);
  import abwc_pkg::*;

  localparam int DEPTH = MAX_SURFACE_WIDTH * MAX_SURFACE_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               in_fire;
  op_ctl_t            in_ctl;
  logic [AW-1:0]      in_addr;
  logic [ALPHA_W-1:0] in_alpha;
  logic [COLOR_W-1:0] in_color;
  logic               in_needs_dst;
  logic               hazard;

  logic               s1_valid_q;
  op_ctl_t            s1_ctl_q;
  logic [AW-1:0]      s1_addr_q;
  logic [COLOR_W-1:0] s1_color_q;
  logic [ALPHA_W-1:0] s1_alpha_q;
  logic               s1_writes, s1_needs_dst;

  logic               s2_valid_q;
  op_ctl_t            s2_ctl_q;
  logic [AW-1:0]      s2_addr_q;
  logic [COLOR_W-1:0] s2_color_q;
  logic [COLOR_W-1:0] s2_dst_q;
  logic               s2_writes;

  logic               out_valid_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_written_q, out_clipped_q, out_last_q;

  logic               wb_valid_q;
  logic [AW-1:0]      wb_addr_q;
  logic [COLOR_W-1:0] wb_data_q;

  logic               out_free, s2_go, s1_go;
  logic               mem_we;
  logic [COLOR_W-1:0] mem_wdata, ram_rdata, dst, mix_color;

  assign in_color = s_axis_tdata[PC_LSB +: COLOR_W];

  abwc_front #(
    .MAX_W (MAX_SURFACE_WIDTH),
    .MAX_H (MAX_SURFACE_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (in_fire),
    .cmd_i         (s_axis_tuser),
    .origin_x_i    (s_axis_tdata[OX_LSB +: COORD_W]),
    .origin_y_i    (s_axis_tdata[OY_LSB +: COORD_W]),
    .rect_width_i  (s_axis_tdata[RW_LSB +: SIZE_W]),
    .rect_height_i (s_axis_tdata[RH_LSB +: SIZE_W]),
    .blend_mode_i  (s_axis_tdata[BM_LSB +: MODE_W]),
    .const_alpha_i (s_axis_tdata[CA_LSB +: ALPHA_W]),
    .pixel_alpha_i (in_color[COLOR_W-1 -: ALPHA_W]),
    .ctl_o         (in_ctl),
    .addr_o        (in_addr),
    .alpha_o       (in_alpha)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_go    = !s2_valid_q || out_free;
  assign s1_go    = !s1_valid_q || s2_go;

  assign in_needs_dst = in_ctl.on_surf &&
                        (in_ctl.is_read || (in_ctl.is_pixel && in_ctl.blend));
  assign s1_writes    = s1_ctl_q.is_pixel && s1_ctl_q.on_surf;
  assign s1_needs_dst = s1_ctl_q.on_surf &&
                        (s1_ctl_q.is_read || (s1_ctl_q.is_pixel && s1_ctl_q.blend));
  assign s2_writes    = s2_ctl_q.is_pixel && s2_ctl_q.on_surf;

  // Hold a beat whose word is still being written ahead of it. A write leaving stage two
  // this cycle is caught by the write-back register instead.
  assign hazard = in_needs_dst &&
                  ((s1_valid_q && s1_writes && (s1_addr_q == in_addr)) ||
                   (s2_valid_q && s2_writes && !out_free && (s2_addr_q == in_addr)));

  assign s_axis_tready = s1_go && !hazard;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  abwc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s2_addr_q),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign dst = (wb_valid_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : ram_rdata;

  abwc_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (s2_go),
    .src_i   (s1_color_q),
    .dst_i   (dst),
    .alpha_i (s1_alpha_q),
    .blend_o (mix_color)
  );

  assign mem_we    = s2_valid_q && out_free && s2_writes;
  assign mem_wdata = s2_ctl_q.blend ? mix_color : s2_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid_q <= in_fire;
      end
      if (s2_go) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
      if (mem_we) begin
        wb_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q   <= in_ctl;
      s1_addr_q  <= in_addr;
      s1_color_q <= in_color;
      s1_alpha_q <= in_alpha;
    end
    if (s2_go) begin
      s2_ctl_q   <= s1_ctl_q;
      s2_addr_q  <= s1_addr_q;
      s2_color_q <= s1_color_q;
      s2_dst_q   <= dst;
    end
    if (out_free && s2_valid_q) begin
      out_color_q   <= (s2_ctl_q.is_read && s2_ctl_q.on_surf) ? s2_dst_q : '0;
      out_written_q <= s2_writes;
      out_clipped_q <= s2_ctl_q.is_pixel && !s2_ctl_q.on_surf;
      out_last_q    <= s2_ctl_q.last;
    end
    if (mem_we) begin
      wb_addr_q <= s2_addr_q;
      wb_data_q <= mem_wdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_color_q;
  assign m_axis_tuser  = {out_clipped_q, out_written_q};
  assign m_axis_tlast  = out_last_q;

  `ABWC_ASSERT_NOW(a_written_xor_clipped, clk_i, rst_ni, m_axis_tvalid,
                   !(m_axis_tuser[0] && m_axis_tuser[1]),
                   "pixel beat both written and clipped")
  `ABWC_ASSERT_NOW(a_colour_only_on_read, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser != '0), m_axis_tdata == '0,
                   "pixel beat carries a read colour")
  `ABWC_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_fire, s1_valid_q,
                    "accepted beat lost before stage one")
  `ABWC_ASSERT_NOW(a_no_raw_overlap, clk_i, rst_ni,
                   s1_valid_q && s1_needs_dst && s2_valid_q && s2_writes,
                   s1_addr_q != s2_addr_q, "read of a word still being written back")

endmodule

// File: tb/sv/alpha_blit_with_clipping_unit_tb.sv
`timescale 1ns / 100ps

module alpha_blit_with_clipping_unit_tb;
  import abwc_pkg::*;

  localparam int STORE_W     = 256;
  localparam int STORE_H     = 256;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 25;

  localparam logic [CMD_W-1:0]     CMD_NOP     = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [SIZE_W-1:0]  rw;
    logic [SIZE_W-1:0]  rh;
    logic [MODE_W-1:0]  mode;
    logic [ALPHA_W-1:0] alpha;
    logic [COLOR_W-1:0] color;
  } blit_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               written;
    logic               clipped;
    logic               done;
  } blit_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [COLOR_W-1:0]    m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  alpha_blit_with_clipping_unit #(
    .MAX_SURFACE_WIDTH (STORE_W),
    .MAX_SURFACE_HEIGHT(STORE_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the blitter state
  logic [COLOR_W-1:0] frame_copy [0:STORE_W*STORE_H-1];
  bit                 filled     [0:STORE_W*STORE_H-1];
  int                 filled_list[$];
  int                 surf_w    = STORE_W;
  int                 surf_h    = STORE_H;
  int                 org_x     = 0;
  int                 org_y     = 0;
  int                 n_cols    = 1;
  int                 n_rows    = 1;
  logic [MODE_W-1:0]  cur_mode  = MODE_COPY;
  logic [ALPHA_W-1:0] cur_alpha = '0;
  int                 col_idx   = 0;
  int                 row_idx   = 0;

  blit_res_t expected_q[$];

  int  n_sent = 0, n_checked = 0, n_errors = 0;
  int  n_written = 0, n_clipped = 0, n_done = 0, n_reads = 0;
  bit  tx_idle = 1'b1, rx_idle = 1'b1, hold_req = 1'b0;
  int  rx_hold_left = 0, rx_gap_left = 0, idle_cycles = 0;

  function automatic int size_clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit on_surf(int x, int y);
    return x >= 0 && y >= 0 && x < surf_w && y < surf_h;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int sum;
    sum = int'(a) * int'(s) + (255 - int'(a)) * int'(d);
    return 8'((sum + 127) / 255);
  endfunction

  // Mix RGB, keep the destination alpha
  function automatic logic [COLOR_W-1:0] blend_argb(logic [COLOR_W-1:0] src,
                                                    logic [COLOR_W-1:0] dst,
                                                    logic [7:0] a);
    return {dst[31:24], blend_channel(src[23:16], dst[23:16], a),
            blend_channel(src[15:8], dst[15:8], a), blend_channel(src[7:0], dst[7:0], a)};
  endfunction

  task automatic blit_apply(input blit_cmd_t c);
    blit_res_t r;
    int x, y, addr;
    logic [COLOR_W-1:0] dst;
    r = '0;
    case (c.cmd)
      CMD_BEGIN: begin
        org_x     = int'($signed(c.ox));
        org_y     = int'($signed(c.oy));
        n_cols    = size_clamp(int'(c.rw), int'(RECT_MAX));
        n_rows    = size_clamp(int'(c.rh), int'(RECT_MAX));
        cur_mode  = c.mode;
        cur_alpha = c.alpha;
        col_idx   = 0;
        row_idx   = 0;
      end
      CMD_PIXEL: begin
        x = org_x + col_idx;
        y = org_y + row_idx;
        if (on_surf(x, y)) begin
          addr = y * STORE_W + x;
          dst  = frame_copy[addr];
          case (cur_mode)
            MODE_SRC_ALPHA:   frame_copy[addr] = blend_argb(c.color, dst, c.color[31:24]);
            MODE_CONST_ALPHA: frame_copy[addr] = blend_argb(c.color, dst, cur_alpha);
            default:          frame_copy[addr] = c.color;
          endcase
          if (!filled[addr]) begin
            filled[addr] = 1'b1;
            filled_list.push_back(addr);
          end
          r.written = 1'b1;
          n_written++;
        end else begin
          r.clipped = 1'b1;
          n_clipped++;
        end
        // advance in raster order, wrap to the top-left corner
        if (col_idx + 1 >= n_cols) begin
          col_idx = 0;
          if (row_idx + 1 >= n_rows) begin
            row_idx = 0;
            r.done  = 1'b1;
            n_done++;
          end else begin
            row_idx++;
          end
        end else begin
          col_idx++;
        end
      end
      CMD_READ: begin
        x = int'($signed(c.ox));
        y = int'($signed(c.oy));
        if (on_surf(x, y)) begin
          r.color = frame_copy[y * STORE_W + x];
          n_reads++;
        end
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endtask

  // True when every on-surface target of the first npix pixels already holds a value
  function automatic bit targets_filled(int ox, int oy, int cols, int rows, int npix);
    int c, r;
    c = 0;
    r = 0;
    for (int i = 0; i < npix; i++) begin
      if (on_surf(ox + c, oy + r) && !filled[(oy + r) * STORE_W + ox + c]) return 1'b0;
      if (c + 1 >= cols) begin
        c = 0;
        r = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_fields(blit_cmd_t c);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[OX_LSB +: COORD_W] = c.ox;
    d[OY_LSB +: COORD_W] = c.oy;
    d[RW_LSB +: SIZE_W]  = c.rw;
    d[RH_LSB +: SIZE_W]  = c.rh;
    d[BM_LSB +: MODE_W]  = c.mode;
    d[CA_LSB +: ALPHA_W] = c.alpha;
    d[PC_LSB +: COLOR_W] = c.color;
    return d;
  endfunction

  function automatic blit_cmd_t rand_fields(logic [CMD_W-1:0] cmd);
    blit_cmd_t c;
    c.cmd   = cmd;
    c.ox    = 11'($urandom);
    c.oy    = 11'($urandom);
    c.rw    = 9'($urandom);
    c.rh    = 9'($urandom);
    c.mode  = 2'($urandom);
    c.alpha = 8'($urandom);
    c.color = $urandom;
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [COLOR_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0:       v[31:24] = 8'h00;
      1:       v[31:24] = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return int'($signed(11'($urandom)));
    return int'($urandom_range(0, 40)) - 8;
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_cmd(input blit_cmd_t c);
    int gap;
    gap = (tx_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= pack_fields(c);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blit_apply(c);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic begin_rect(input int ox, input int oy, input int w, input int h,
                            input logic [MODE_W-1:0] mode, input logic [ALPHA_W-1:0] alpha);
    blit_cmd_t c;
    c       = rand_fields(CMD_BEGIN);
    c.ox    = 11'(ox);
    c.oy    = 11'(oy);
    c.rw    = 9'(w);
    c.rh    = 9'(h);
    c.mode  = mode;
    c.alpha = alpha;
    send_cmd(c);
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] color);
    blit_cmd_t c;
    c       = rand_fields(CMD_PIXEL);
    c.color = color;
    send_cmd(c);
  endtask

  task automatic send_read(input int x, input int y);
    blit_cmd_t c;
    c    = rand_fields(CMD_READ);
    c.ox = 11'(x);
    c.oy = 11'(y);
    send_cmd(c);
  endtask

  // Drop valid and let every outstanding result drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == REG_SURF_W) surf_w = size_clamp(int'(val), STORE_W);
    else if (idx == REG_SURF_H) surf_h = size_clamp(int'(val), STORE_H);
  endtask

  task automatic set_surface(input int w, input int h);
    drain();
    cfg_write(REG_SURF_W, 9'(w));
    cfg_write(REG_SURF_H, 9'(h));
  endtask

  task automatic random_rect();
    int ox, oy, w, h, cols, rows, npix;
    logic [MODE_W-1:0] mode;
    ox = rand_coord();
    oy = rand_coord();
    w  = $urandom_range(1, 8);
    h  = $urandom_range(1, 4);
    if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 511);
    if ($urandom_range(0, 15) == 0) h = $urandom_range(0, 511);
    cols = size_clamp(w, int'(RECT_MAX));
    rows = size_clamp(h, int'(RECT_MAX));
    npix = cols * rows;
    case ($urandom_range(0, 5))
      0:       npix = $urandom_range(1, npix);
      1:       npix = npix + $urandom_range(1, npix);
      default: ;
    endcase
    if (npix > 40) npix = $urandom_range(1, 40);
    mode = 2'($urandom);
    // blend only onto words that already hold a value
    if ((mode == MODE_SRC_ALPHA || mode == MODE_CONST_ALPHA) &&
        !targets_filled(ox, oy, cols, rows, npix))
      mode = MODE_COPY;
    begin_rect(ox, oy, w, h, mode, pick_alpha());
    repeat (npix) send_pixel(pick_color());
  endtask

  task automatic random_read();
    int x, y, addr;
    if (filled_list.size() > 0 && $urandom_range(0, 3) != 0) begin
      addr = filled_list[$urandom_range(0, filled_list.size() - 1)];
      x    = addr % STORE_W;
      y    = addr / STORE_W;
    end else begin
      x = rand_coord();
      y = rand_coord();
      if (on_surf(x, y) && !filled[y * STORE_W + x]) x = -1 - x;
    end
    send_read(x, y);
  endtask

  // Stray pixel for the open rectangle, or a read if it would blend onto no value
  task automatic stray_pixel();
    int x, y;
    x = org_x + col_idx;
    y = org_y + row_idx;
    if ((cur_mode == MODE_SRC_ALPHA || cur_mode == MODE_CONST_ALPHA) &&
        on_surf(x, y) && !filled[y * STORE_W + x])
      random_read();
    else
      send_pixel(pick_color());
  endtask

  task automatic random_step();
    int k;
    k = $urandom_range(0, 19);
    if (k < 11) random_rect();
    else if (k < 15) random_read();
    else if (k < 17) stray_pixel();
    else if (k == 17) send_cmd(rand_fields(CMD_NOP));
    else begin_rect(rand_coord(), rand_coord(), $urandom_range(0, 511),
                    $urandom_range(0, 511), 2'($urandom), pick_alpha());
  endtask

  task automatic test_before_begin();
    send_pixel(32'hA1B2C3D4);
    send_pixel(32'h5E6F7081);
    send_read(0, 0);
  endtask

  task automatic test_surface_registers();
    drain();
    cfg_write(REG_SURF_W, '0);
    cfg_write(REG_SURF_H, '1);
    cfg_write(REG_SPARE_A, 9'd3);
    cfg_write(REG_SPARE_B, '0);
    begin_rect(0, 0, 2, 1, MODE_COPY, 8'h00);
    send_pixel($urandom);
    send_pixel($urandom);
    send_read(1, 0);
    set_surface(STORE_W, STORE_H);
  endtask

  task automatic test_blend_modes();
    begin_rect(8, 0, 3, 1, MODE_COPY, 8'h00);
    send_pixel(32'hFF1080F0);
    send_pixel(32'h80FF0001);
    send_pixel(32'h0000FF7F);
    begin_rect(8, 0, 3, 1, MODE_SRC_ALPHA, 8'h00);
    send_pixel(32'h00FFFFFF);
    send_pixel(32'hFF123456);
    send_pixel(32'h80A00B50);
    begin_rect(8, 0, 2, 1, MODE_CONST_ALPHA, 8'h5A);
    send_pixel(32'h00FF00FF);
    send_pixel(32'hFF00FF00);
    begin_rect(10, 0, 1, 1, MODE_SPARE, 8'hFF);
    send_pixel(32'h7F7F7F7F);
    send_read(8, 0);
    send_read(10, 0);
  endtask

  task automatic test_rect_edges();
    begin_rect(-1024, 1023, 0, 300, MODE_COPY, 8'h00);
    send_pixel($urandom);
    send_cmd(rand_fields(CMD_NOP));
    begin_rect(-1, -1, 2, 2, MODE_COPY, 8'h00);
    repeat (4) send_pixel($urandom);
    send_read(1023, -1024);
  endtask

  // Width above the rectangle maximum: the row closes after 256 pixels, then wraps
  task automatic test_wide_row();
    int ox, w;
    ox = -int'($urandom_range(0, 250));
    w  = $urandom_range(257, 511);
    begin_rect(ox, $urandom_range(0, 15), w, 1,
               ($urandom_range(0, 1) != 0) ? MODE_COPY : MODE_SPARE, pick_alpha());
    repeat (int'(RECT_MAX) + 1) send_pixel(pick_color());
  endtask

  task automatic test_backpressure();
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    begin_rect(0, 4, 8, 4, MODE_COPY, 8'h00);
    repeat (32) send_pixel(pick_color());
    tx_idle = 1'b1;
  endtask

  task automatic test_random();
    int goal;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_surface(STORE_W, STORE_H);
        1:       set_surface(1, 1);
        2:       set_surface($urandom_range(2, 40), $urandom_range(2, 40));
        3:       set_surface(511, 0);
        4:       set_surface($urandom_range(0, 511), $urandom_range(0, 511));
        default: set_surface(STORE_W, $urandom_range(1, 64));
      endcase
      if (p == 2) cfg_write(REG_SPARE_A, 9'($urandom));
      // one phase without idling on either side
      tx_idle = (p != 3);
      rx_idle = (p != 3);
      goal = n_sent + PHASE_ITEMS;
      while (n_sent < goal) random_step();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_quiet_tail();
    int goal;
    set_surface(STORE_W, STORE_H);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    goal = n_sent + 40;
    while (n_sent < goal) random_step();
  endtask

  task automatic log_mismatch(input string what, input blit_res_t want, input blit_res_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%s: expected colour %h wr %b clip %b done %b, got colour %h wr %b clip %b done %b",
               what, want.color, want.written, want.clipped, want.done,
               got.color, got.written, got.clipped, got.done);
  endtask

  // Result beats
  always @(posedge clk_i) begin : check_results
    blit_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.color   = m_axis_tdata;
      got.written = m_axis_tuser[0];
      got.clipped = m_axis_tuser[1];
      got.done    = m_axis_tlast;
      n_checked++;
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected result beat", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.color !== want.color || got.written !== want.written ||
            got.clipped !== want.clipped || got.done !== want.done)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req     = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      rx_gap_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("alpha_blit_with_clipping_unit_tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_SURF_W;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_BEGIN;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_before_begin();
    test_surface_registers();
    test_blend_modes();
    test_rect_edges();
    test_wide_row();
    test_backpressure();
    test_random();
    test_quiet_tail();

    drain();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d command beats over six surface sizes: %0d pixels written, %0d clipped,",
             n_sent, n_written, n_clipped);
    $display("%0d rectangles closed, %0d on-surface reads; %0d result beats checked, %0d bad.",
             n_done, n_reads, n_checked, n_errors);
    if (n_errors == 0) $display("alpha_blit_with_clipping_unit_tb passed");
    else $display("alpha_blit_with_clipping_unit_tb failed");
    $finish;
  end

endmodule
